### sv/pbts_pkg.sv
// ----------------------------------------------------------------------------
// pbts_pkg
// Shared types and constants of the priority bitmap task scheduler.
// ----------------------------------------------------------------------------
package pbts_pkg;

	localparam int NUM_PRIORITIES_DEF = 32;
	localparam int TICK_BITS_DEF      = 32;

	localparam logic [31:0] PRESENT_RESET = 32'h8000_0000;

	localparam logic [2:0] CMD_TICK     = 3'd0;
	localparam logic [2:0] CMD_DELAY    = 3'd1;
	localparam logic [2:0] CMD_SUSPEND  = 3'd2;
	localparam logic [2:0] CMD_RESUME   = 3'd3;
	localparam logic [2:0] CMD_SCHEDULE = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_PICK
	} state_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [4:0]  task_prio;
		logic [31:0] delay_ticks;
	} request_t;

	typedef struct packed {
		logic [4:0]  next_task;
		logic        switch_needed;
		logic [31:0] ready_bits;
	} result_t;

endpackage

### sv/pbts_ram.sv
// ----------------------------------------------------------------------------
// pbts_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pbts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/priority_bitmap_task_scheduler.sv
// ----------------------------------------------------------------------------
// priority_bitmap_task_scheduler
// Scheduler with one task per priority; delay counters live in a RAM.
// ----------------------------------------------------------------------------
// Tick: busy while the counters are read, one a cycle through the counter RAM port,
//   then while the last write-back finishes and while the pick is made; the result
//   strobe comes in the cycle busy falls. Other commands: busy while the pick is
//   made, result in the next cycle.
// Next request may start in the cycle the result is shown.
// Reset: asynchronous; counters read as zero until written, idle task current.
// ----------------------------------------------------------------------------
module priority_bitmap_task_scheduler #(
	parameter int NUM_PRIORITIES = pbts_pkg::NUM_PRIORITIES_DEF,
	parameter int TICK_BITS      = pbts_pkg::TICK_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  pbts_pkg::request_t req,
	output logic               done,
	output pbts_pkg::result_t  rsp,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        cfg_data
);

	localparam int PRIO_W = $clog2(NUM_PRIORITIES);
	localparam int IDX_W  = $clog2(NUM_PRIORITIES + 1);
	localparam logic [PRIO_W-1:0]         IDLE_PRIO   = PRIO_W'(NUM_PRIORITIES - 1);
	localparam logic [IDX_W-1:0]          SWEEP_END   = IDX_W'(NUM_PRIORITIES);
	localparam logic [NUM_PRIORITIES-1:0] PRESENT_RST =
		pbts_pkg::PRESENT_RESET[NUM_PRIORITIES-1:0];

	pbts_pkg::state_t state_q, state_d;

	logic [NUM_PRIORITIES-1:0] present_q;
	logic [NUM_PRIORITIES-1:0] ready_q;
	logic [NUM_PRIORITIES-1:0] susp_q;
	logic [NUM_PRIORITIES-1:0] vld_q;
	logic [PRIO_W-1:0]         cur_q;
	logic [2:0]                cmd_q;
	logic [IDX_W-1:0]          idx_q;
	logic                      tick_s1;
	logic [PRIO_W-1:0]         tidx_s1;
	logic                      done_q;
	pbts_pkg::result_t         rsp_q;

	logic                 accept;
	logic                 cfg_we;
	logic                 prio_ok;
	logic [PRIO_W-1:0]    prio_idx;
	logic                 rd_en;
	logic                 mem_we;
	logic [PRIO_W-1:0]    mem_waddr;
	logic [TICK_BITS-1:0] mem_wdata;
	logic [TICK_BITS-1:0] mem_rdata;
	logic [TICK_BITS-1:0] cnt_s1;
	logic                 tick_we;
	logic                 tick_rdy;
	logic [PRIO_W-1:0]    pick;
	logic                 sched_cmd;

	pbts_ram #(
		.WIDTH (TICK_BITS),
		.DEPTH (NUM_PRIORITIES)
	) u_cnt_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (rd_en),
		.raddr (idx_q[PRIO_W-1:0]),
		.rdata (mem_rdata)
	);

	assign prio_ok  = {1'b0, req.task_prio} < 6'(NUM_PRIORITIES);
	assign prio_idx = req.task_prio[PRIO_W-1:0];

	// never-written counters read as zero
	assign cnt_s1   = vld_q[tidx_s1] ? mem_rdata : '0;
	assign tick_we  = tick_s1 && present_q[tidx_s1] && (cnt_s1 != '0);
	assign tick_rdy = tick_s1 && present_q[tidx_s1] && !susp_q[tidx_s1]
		&& (cnt_s1 <= TICK_BITS'(1));

	assign sched_cmd = (cmd_q == pbts_pkg::CMD_DELAY) || (cmd_q == pbts_pkg::CMD_SCHEDULE);

	// highest priority is the lowest set bit; idle task when none is set
	always_comb begin
		pick = IDLE_PRIO;
		for (int i = NUM_PRIORITIES - 1; i >= 0; i--) begin
			if (ready_q[i]) begin
				pick = PRIO_W'(i);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pbts_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (req.command == pbts_pkg::CMD_TICK) ?
						pbts_pkg::ST_TICK : pbts_pkg::ST_PICK;
				end
			end
			pbts_pkg::ST_TICK: begin
				// last write-back happens in this cycle
				if (idx_q == SWEEP_END) begin
					state_d = pbts_pkg::ST_PICK;
				end
			end
			pbts_pkg::ST_PICK: begin
				state_d = pbts_pkg::ST_IDLE;
			end
			default: begin
				state_d = pbts_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy      = (state_q != pbts_pkg::ST_IDLE);
		accept    = start && !busy;
		cfg_ready = !busy && !start;
		cfg_we    = cfg_valid && cfg_ready;
		rd_en     = (state_q == pbts_pkg::ST_TICK) && (idx_q < SWEEP_END);
		if (state_q == pbts_pkg::ST_TICK) begin
			mem_we    = tick_we;
			mem_waddr = tidx_s1;
			mem_wdata = cnt_s1 - TICK_BITS'(1);
		end else begin
			mem_we    = accept && (req.command == pbts_pkg::CMD_DELAY);
			mem_waddr = cur_q;
			mem_wdata = req.delay_ticks[TICK_BITS-1:0];
		end
		done = done_q;
		rsp  = rsp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pbts_pkg::ST_IDLE;
			present_q <= PRESENT_RST;
			ready_q   <= PRESENT_RST;
			susp_q    <= '0;
			vld_q     <= '0;
			cur_q     <= IDLE_PRIO;
			cmd_q     <= pbts_pkg::CMD_TICK;
			idx_q     <= '0;
			tick_s1   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			tick_s1 <= rd_en;
			done_q  <= (state_q == pbts_pkg::ST_PICK);

			if (mem_we) begin
				vld_q[mem_waddr] <= 1'b1;
			end

			if (accept) begin
				cmd_q <= req.command;
				idx_q <= '0;
			end else if (rd_en) begin
				idx_q <= idx_q + IDX_W'(1);
			end

			if (cfg_we) begin
				present_q <= cfg_data[NUM_PRIORITIES-1:0];
				ready_q   <= cfg_data[NUM_PRIORITIES-1:0];
			end else if (accept) begin
				unique case (req.command)
					pbts_pkg::CMD_DELAY: begin
						ready_q[cur_q] <= 1'b0;
					end
					pbts_pkg::CMD_SUSPEND: begin
						if (prio_ok) begin
							ready_q[prio_idx] <= 1'b0;
							susp_q[prio_idx]  <= 1'b1;
						end
					end
					pbts_pkg::CMD_RESUME: begin
						if (prio_ok) begin
							susp_q[prio_idx] <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end else if (tick_rdy) begin
				ready_q[tidx_s1] <= 1'b1;
			end

			if (state_q == pbts_pkg::ST_PICK && sched_cmd) begin
				cur_q <= pick;
			end
		end
	end

	// sweep pipeline and result registers carry no reset
	always_ff @(posedge clk) begin
		tidx_s1 <= idx_q[PRIO_W-1:0];
		if (state_q == pbts_pkg::ST_PICK) begin
			rsp_q.next_task     <= 5'(pick);
			rsp_q.switch_needed <= sched_cmd && (pick != cur_q);
			rsp_q.ready_bits    <= 32'(ready_q);
		end
	end

endmodule
